[hdl/brti_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brti_pkg: shared types and constants for binary64 round to integral
// Field widths, special encodings and the function select codes.
// ----------------------------------------------------------------------------
package brti_pkg;

	localparam int unsigned EXP_W  = 11;
	localparam int unsigned MANT_W = 52;
	localparam int unsigned LZ_W   = 6;

	localparam logic [EXP_W-1:0] EXP_MAX      = 11'h7FF;
	localparam logic [EXP_W-1:0] EXP_BIAS     = 11'd1023;
	localparam logic [EXP_W-1:0] EXP_INTEGRAL = 11'd1075;
	localparam logic [63:0]      DEFAULT_NAN  = 64'h7FF8_0000_0000_0000;
	localparam logic [63:0]      QUIET_BIT    = 64'h0008_0000_0000_0000;
	localparam logic [63:0]      POS_ONE      = 64'h3FF0_0000_0000_0000;
	localparam logic [63:0]      NEG_ONE      = 64'hBFF0_0000_0000_0000;

	typedef enum logic [1:0] {
		FUNC_INT   = 2'd0,
		FUNC_FRAC  = 2'd1,
		FUNC_FLOOR = 2'd2,
		FUNC_CEIL  = 2'd3
	} func_t;

	// Renormalized fraction handed from the normalizer to the datapath
	typedef struct packed {
		logic [EXP_W-1:0]  exp;
		logic [MANT_W-1:0] mant;
	} norm_t;

endpackage
`default_nettype wire

[hdl/binary64_round_to_integral.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// binary64_round_to_integral: trunc, fraction, floor and ceil on binary64
// Registered single pass: input register, short datapath, result register.
// ----------------------------------------------------------------------------
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------
//  op       | op_valid / op_ready   | func[1:0], operand_bits[63:0]
//  res      | res_valid / res_ready | result_bits[63:0]
//
//  res_valid rises once an accepted item has passed the input register
//  and then the result register; one item per cycle is accepted as long
//  as res_ready keeps up, on the single pass through mask, normalize and
//  increment to the result register. Reset clears both valid flags;
//  payload registers are not reset. A stall on res holds the result
//  register and fills the input register, then op_ready drops until taken.
// ----------------------------------------------------------------------------
module binary64_round_to_integral
	import brti_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        op_valid,
	output logic             op_ready,
	input  wire logic [1:0]  func,
	input  wire logic [63:0] operand_bits,
	output logic             res_valid,
	input  wire logic        res_ready,
	output logic [63:0]      result_bits
);

	logic        valid_s1;
	logic [1:0]  func_s1;
	logic [63:0] operand_s1;
	logic        valid_s2;
	logic [63:0] result_s2;
	logic [63:0] calc_result;
	logic        s2_free;
	logic        adv_s1;

	// result register can take a new item when empty or being drained
	assign s2_free  = !valid_s2 || res_ready;
	assign adv_s1   = valid_s1 && s2_free;
	assign op_ready = !valid_s1 || s2_free;

	// input register: capture each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (op_ready) begin
			valid_s1 <= op_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (op_valid && op_ready) begin
			func_s1    <= func;
			operand_s1 <= operand_bits;
		end
	end

	brti_calc u_calc (
		.func         (func_s1),
		.operand_bits (operand_s1),
		.result_bits  (calc_result)
	);

	// result register: hold while stalled, advance otherwise
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_s2 <= calc_result;
		end
	end

	assign res_valid   = valid_s2;
	assign result_bits = result_s2;

	// an empty result register never blocks the input side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> op_ready)
		else $error("op_ready low with empty result register");

	// an accepted item always lands in the input register
	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(op_valid && op_ready) |=> valid_s1)
		else $error("accepted item lost at input register");

	// a pending item moves on when the result register is empty
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !valid_s2) |=> valid_s2)
		else $error("item failed to advance to result register");

endmodule
`default_nettype wire

[hdl/brti_norm.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brti_norm: fraction renormalizer
// Finds the leading one of the leftover mantissa bits and rebuilds a normal
// binary64 exponent and mantissa for the fractional part.
// ----------------------------------------------------------------------------
module brti_norm
	import brti_pkg::*;
(
	input  wire logic [EXP_W-1:0]  field,
	input  wire logic [MANT_W-1:0] frac_m,
	output norm_t                  norm
);

	logic [LZ_W-1:0]   lz;
	logic [MANT_W:0]   shifted;

	// leading zero count; highest set position wins last, so scan upward
	always_comb begin
		lz = LZ_W'(MANT_W - 1);
		for (int i = 0; i < MANT_W; i++) begin
			if (frac_m[i]) begin
				lz = LZ_W'(MANT_W - 1 - i);
			end
		end
	end

	always_comb begin
		shifted   = {1'b0, frac_m} << lz;
		norm.mant = {shifted[MANT_W-2:0], 1'b0};
		norm.exp  = field - 11'd1 - EXP_W'(lz);
	end

endmodule
`default_nettype wire

[hdl/brti_calc.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brti_calc: integer part, fraction, floor and ceiling datapath
// Classify the operand, mask off the bits below the binary point, and pick
// the selected result.
// ----------------------------------------------------------------------------
module brti_calc
	import brti_pkg::*;
(
	input  wire logic [1:0]  func,
	input  wire logic [63:0] operand_bits,
	output logic [63:0]      result_bits
);

	logic              sign;
	logic [EXP_W-1:0]  field;
	logic [MANT_W-1:0] mant;
	logic              is_nan, is_inf, is_small, is_big, nonzero;
	logic [LZ_W-1:0]   e_mid;
	logic [LZ_W-1:0]   sh;
	logic [MANT_W-1:0] low_mask;
	logic [MANT_W-1:0] frac_m;
	logic              frac_nz;
	logic [63:0]       ip_bits, fr_bits, step_bits;
	logic [62:0]       unit;
	logic              fr_neg, fr_pos;
	norm_t             norm;
	func_t             fsel;

	assign sign  = operand_bits[63];
	assign field = operand_bits[62:52];
	assign mant  = operand_bits[51:0];

	assign is_nan   = (field == EXP_MAX) && (mant != '0);
	assign is_inf   = (field == EXP_MAX) && (mant == '0);
	assign is_small = field < EXP_BIAS;
	assign is_big   = field >= EXP_INTEGRAL;
	assign nonzero  = operand_bits[62:0] != '0;

	assign e_mid    = LZ_W'(field - EXP_BIAS);
	assign sh       = LZ_W'(MANT_W) - e_mid;
	assign low_mask = ~({MANT_W{1'b1}} << sh);
	assign frac_m   = mant & low_mask;
	assign frac_nz  = frac_m != '0;
	assign unit     = 63'(1) << sh;

	brti_norm u_norm (
		.field  (field),
		.frac_m (frac_m),
		.norm   (norm)
	);

	always_comb begin
		fsel = func_t'(func);
		if (is_small) begin
			ip_bits   = {sign, 63'd0};
			fr_bits   = operand_bits;
			fr_neg    = sign && nonzero;
			fr_pos    = !sign && nonzero;
			step_bits = sign ? NEG_ONE : POS_ONE;
		end else if (is_big) begin
			ip_bits   = operand_bits;
			fr_bits   = is_inf ? DEFAULT_NAN : {sign, 63'd0};
			fr_neg    = 1'b0;
			fr_pos    = 1'b0;
			step_bits = operand_bits;
		end else begin
			ip_bits   = {sign, field, mant & ~low_mask};
			fr_bits   = frac_nz ? {sign, norm.exp, norm.mant} : 64'd0;
			fr_neg    = sign && frac_nz;
			fr_pos    = !sign && frac_nz;
			// magnitude grows by one unit; a carry rolls into the exponent
			step_bits = {sign, ip_bits[62:0] + unit};
		end

		case (fsel)
			FUNC_INT:   result_bits = ip_bits;
			FUNC_FRAC:  result_bits = fr_bits;
			FUNC_FLOOR: result_bits = fr_neg ? step_bits : ip_bits;
			FUNC_CEIL:  result_bits = fr_pos ? step_bits : ip_bits;
			default:    result_bits = ip_bits;
		endcase

		if (is_nan) begin
			result_bits = operand_bits | QUIET_BIT;
		end
	end

endmodule
`default_nettype wire
